FILE: rtl/core/barometric_pressure_compensation_defines.svh
// Assertion helpers for the pressure compensation block.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH

`ifndef SYNTHESIS
// check that is held off while reset is high
`define BPC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bpc assertion failed");
// check that also holds across reset
`define BPC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("bpc assertion failed");
`else
`define BPC_ASSERT(lbl, clk, rst, prop)
`define BPC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/core/bpc_pkg.sv
package bpc_pkg;

   // register indexes on the csr port
   localparam logic [2:0] REG_PRESS_SENS  = 3'd0;
   localparam logic [2:0] REG_PRESS_OFF   = 3'd1;
   localparam logic [2:0] REG_SENS_TCO    = 3'd2;
   localparam logic [2:0] REG_OFF_TCO     = 3'd3;
   localparam logic [2:0] REG_REF_TEMP    = 3'd4;
   localparam logic [2:0] REG_TEMP_SENS   = 3'd5;
   localparam logic [2:0] REG_VARIANT     = 3'd6;

   // centi-degree constants and the temperature scale
   localparam logic signed [20:0] TEMP_REF    = 21'sd2000;
   localparam logic signed [20:0] TEMP_COLD   = -21'sd1500;
   localparam logic signed [17:0] TEMP_SCALE  = 18'sd83886;

   // second-order factors
   localparam logic signed [47:0] K_OFF2_V0  = 48'sd61;
   localparam logic signed [47:0] K_OFFE_V0  = 48'sd15;
   localparam logic signed [47:0] K_SENSE_V0 = 48'sd8;
   localparam logic signed [47:0] K_D_V1     = 48'sd5;
   localparam logic signed [47:0] K_OFFE_V1  = 48'sd7;
   localparam logic signed [47:0] K_SENSE_V1 = 48'sd11;

   typedef struct packed {
      logic [23:0] raw_pressure;
      logic [23:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pressure_q8;
      logic signed [31:0] temperature_q8;
      logic               result_valid;
   } rsp_type;

   typedef struct packed {
      logic [15:0] press_sens;
      logic [15:0] press_off;
      logic [15:0] sens_tco;
      logic [15:0] off_tco;
      logic [15:0] ref_temp;
      logic [15:0] temp_sens;
      logic        variant;
   } cfg_type;

   // first-order terms
   typedef struct packed {
      logic [23:0]        rp;
      logic               bad;
      logic signed [19:0] temp;
      logic signed [47:0] off;
      logic signed [47:0] sens;
      logic signed [19:0] t2;
   } first_type;

   // corrected terms
   typedef struct packed {
      logic [23:0]        rp;
      logic               bad;
      logic signed [47:0] off;
      logic signed [39:0] sens;
      logic signed [20:0] tmt;
   } corr_type;

endpackage

FILE: rtl/core/bpc_first.sv
module bpc_first (
   input  logic               clock,
   input  logic               reset,
   input  bpc_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  bpc_pkg::req_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output bpc_pkg::first_type out_data
);
   import bpc_pkg::*;

   logic [2:0] v_ff, v_in, en;

   // stage 1: dT
   logic [23:0]        s1_rp_ff;
   logic               s1_bad_ff;
   logic signed [24:0] s1_dt_ff, s1_dt_in;
   // stage 2: products with dT
   logic [23:0]        s2_rp_ff;
   logic               s2_bad_ff;
   logic signed [41:0] s2_mt_ff, s2_mt_in;
   logic signed [41:0] s2_mo_ff, s2_mo_in;
   logic signed [41:0] s2_ms_ff, s2_ms_in;
   logic signed [49:0] s2_dd_ff, s2_dd_in;
   // stage 3: TEMP, OFF, SENS, T2
   first_type          s3_ff, s3_in;

   logic signed [41:0] mt_sh, mo_sh, ms_sh;
   logic signed [49:0] dd_sh;
   logic [47:0]        off_base, sens_base;

   assign en[2]    = !v_ff[2] || out_ready;
   assign en[1]    = !v_ff[1] || en[2];
   assign en[0]    = !v_ff[0] || en[1];
   assign in_ready = en[0];

   always_comb begin
      v_in[0] = en[0] ? in_valid : v_ff[0];
      v_in[1] = en[1] ? v_ff[0]  : v_ff[1];
      v_in[2] = en[2] ? v_ff[1]  : v_ff[2];
   end

   assign s1_dt_in = $signed({1'b0, in_data.raw_temperature})
                   - $signed({1'b0, cfg.ref_temp, 8'd0});

   assign s2_mt_in = s1_dt_ff * $signed({1'b0, cfg.temp_sens});
   assign s2_mo_in = s1_dt_ff * $signed({1'b0, cfg.off_tco});
   assign s2_ms_in = s1_dt_ff * $signed({1'b0, cfg.sens_tco});
   assign s2_dd_in = s1_dt_ff * s1_dt_ff;

   always_comb begin
      mt_sh     = s2_mt_ff >>> 23;
      dd_sh     = s2_dd_ff >>> 31;
      mo_sh     = cfg.variant ? (s2_mo_ff >>> 7) : (s2_mo_ff >>> 6);
      ms_sh     = cfg.variant ? (s2_ms_ff >>> 8) : (s2_ms_ff >>> 7);
      off_base  = cfg.variant ? (48'(cfg.press_off) << 16) : (48'(cfg.press_off) << 17);
      sens_base = cfg.variant ? (48'(cfg.press_sens) << 15)
                              : (48'(cfg.press_sens) << 16);
      s3_in.rp   = s2_rp_ff;
      s3_in.bad  = s2_bad_ff;
      s3_in.temp = $signed(mt_sh[19:0]) + 20'(TEMP_REF);
      s3_in.off  = $signed(off_base) + 48'(mo_sh);
      s3_in.sens = $signed(sens_base) + 48'(ms_sh);
      s3_in.t2   = $signed(dd_sh[19:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
      if (en[0]) begin
         s1_rp_ff  <= in_data.raw_pressure;
         s1_bad_ff <= (in_data.raw_pressure == '0) || (in_data.raw_temperature == '0);
         s1_dt_ff  <= s1_dt_in;
      end
      if (en[1]) begin
         s2_rp_ff  <= s1_rp_ff;
         s2_bad_ff <= s1_bad_ff;
         s2_mt_ff  <= s2_mt_in;
         s2_mo_ff  <= s2_mo_in;
         s2_ms_ff  <= s2_ms_in;
         s2_dd_ff  <= s2_dd_in;
      end
      if (en[2]) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = v_ff[2];
   assign out_data  = s3_ff;

endmodule

FILE: rtl/core/bpc_corr.sv
module bpc_corr (
   input  logic               clock,
   input  logic               reset,
   input  bpc_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  bpc_pkg::first_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output bpc_pkg::corr_type  out_data
);
   import bpc_pkg::*;

   logic [2:0] v_ff, v_in, en;

   // stage 4: squares of the temperature distances
   logic [23:0]        s4_rp_ff;
   logic               s4_bad_ff, s4_lo_ff, s4_vlo_ff;
   logic signed [47:0] s4_off_ff, s4_sens_ff;
   logic signed [20:0] s4_tmt_ff;
   logic signed [41:0] s4_dsq_ff, s4_dsq_in, s4_esq_ff, s4_esq_in;
   // stage 5: OFF2, SENS2
   logic [23:0]        s5_rp_ff;
   logic               s5_bad_ff;
   logic signed [47:0] s5_off_ff, s5_sens_ff;
   logic signed [20:0] s5_tmt_ff;
   logic signed [47:0] s5_off2_ff, s5_off2_in, s5_sens2_ff, s5_sens2_in;
   // stage 6: corrected terms
   corr_type           s6_ff, s6_in;

   logic signed [20:0] d, e;
   logic signed [47:0] dsq, esq, off2_d, sens2_d, off2_e, sens2_e;

   assign en[2]    = !v_ff[2] || out_ready;
   assign en[1]    = !v_ff[1] || en[2];
   assign en[0]    = !v_ff[0] || en[1];
   assign in_ready = en[0];

   always_comb begin
      v_in[0] = en[0] ? in_valid : v_ff[0];
      v_in[1] = en[1] ? v_ff[0]  : v_ff[1];
      v_in[2] = en[2] ? v_ff[1]  : v_ff[2];
   end

   assign d         = 21'(in_data.temp) - TEMP_REF;
   assign e         = 21'(in_data.temp) - TEMP_COLD;
   assign s4_dsq_in = d * d;
   assign s4_esq_in = e * e;

   // squares are nonnegative, so the divides are plain shifts
   always_comb begin
      dsq = 48'(s4_dsq_ff);
      esq = 48'(s4_esq_ff);
      if (cfg.variant) begin
         off2_d  = (dsq * K_D_V1) >>> 1;
         sens2_d = (dsq * K_D_V1) >>> 2;
         off2_e  = esq * K_OFFE_V1;
         sens2_e = (esq * K_SENSE_V1) >>> 1;
      end else begin
         off2_d  = (dsq * K_OFF2_V0) >>> 4;
         sens2_d = dsq <<< 1;
         off2_e  = esq * K_OFFE_V0;
         sens2_e = esq * K_SENSE_V0;
      end
      s5_off2_in  = '0;
      s5_sens2_in = '0;
      if (s4_lo_ff) begin
         s5_off2_in  = s4_vlo_ff ? off2_d + off2_e : off2_d;
         s5_sens2_in = s4_vlo_ff ? sens2_d + sens2_e : sens2_d;
      end
   end

   always_comb begin
      s6_in.rp   = s5_rp_ff;
      s6_in.bad  = s5_bad_ff;
      s6_in.off  = s5_off_ff - s5_off2_ff;
      s6_in.sens = 40'(s5_sens_ff - s5_sens2_ff);
      s6_in.tmt  = s5_tmt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
      if (en[0]) begin
         s4_rp_ff   <= in_data.rp;
         s4_bad_ff  <= in_data.bad;
         s4_lo_ff   <= 21'(in_data.temp) < TEMP_REF;
         s4_vlo_ff  <= 21'(in_data.temp) < TEMP_COLD;
         s4_off_ff  <= in_data.off;
         s4_sens_ff <= in_data.sens;
         // T2 only applies below 20.00 C
         s4_tmt_ff  <= (21'(in_data.temp) < TEMP_REF)
                       ? 21'(in_data.temp) - 21'(in_data.t2)
                       : 21'(in_data.temp);
         s4_dsq_ff  <= s4_dsq_in;
         s4_esq_ff  <= s4_esq_in;
      end
      if (en[1]) begin
         s5_rp_ff    <= s4_rp_ff;
         s5_bad_ff   <= s4_bad_ff;
         s5_off_ff   <= s4_off_ff;
         s5_sens_ff  <= s4_sens_ff;
         s5_tmt_ff   <= s4_tmt_ff;
         s5_off2_ff  <= s5_off2_in;
         s5_sens2_ff <= s5_sens2_in;
      end
      if (en[2]) begin
         s6_ff <= s6_in;
      end
   end

   assign out_valid = v_ff[2];
   assign out_data  = s6_ff;

endmodule

FILE: rtl/core/bpc_final.sv
module bpc_final (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  bpc_pkg::corr_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output bpc_pkg::rsp_type  out_data
);
   import bpc_pkg::*;

   logic [2:0] v_ff, v_in, en;

   // stage 7: split product P * SENS, temperature scaling
   logic               s7_bad_ff;
   logic signed [47:0] s7_off_ff;
   logic [43:0]        s7_pp_lo_ff, s7_pp_lo_in;
   logic signed [44:0] s7_pp_hi_ff, s7_pp_hi_in;
   logic signed [38:0] s7_tm_ff, s7_tm_in;
   // stage 8: product sum
   logic               s8_bad_ff;
   logic signed [47:0] s8_off_ff;
   logic signed [47:0] s8_q_ff, s8_q_in;
   logic signed [31:0] s8_t_ff, s8_t_in;
   // stage 9: output register
   rsp_type            s9_ff, s9_in;

   logic signed [65:0] prod, prod_sh;
   logic signed [38:0] tm_sh;
   logic signed [47:0] p_diff, p_sh;

   assign en[2]    = !v_ff[2] || out_ready;
   assign en[1]    = !v_ff[1] || en[2];
   assign en[0]    = !v_ff[0] || en[1];
   assign in_ready = en[0];

   always_comb begin
      v_in[0] = en[0] ? in_valid : v_ff[0];
      v_in[1] = en[1] ? v_ff[0]  : v_ff[1];
      v_in[2] = en[2] ? v_ff[1]  : v_ff[2];
   end

   assign s7_pp_lo_in = in_data.rp * in_data.sens[19:0];
   assign s7_pp_hi_in = $signed({1'b0, in_data.rp}) * $signed(in_data.sens[39:20]);
   assign s7_tm_in    = in_data.tmt * TEMP_SCALE;

   always_comb begin
      prod    = (66'(s7_pp_hi_ff) <<< 20) + $signed({22'd0, s7_pp_lo_ff});
      prod_sh = prod >>> 21;
      s8_q_in = 48'(prod_sh);
      tm_sh   = s7_tm_ff >>> 15;
      s8_t_in = 32'(tm_sh);
   end

   always_comb begin
      p_diff = s8_q_ff - s8_off_ff;
      p_sh   = p_diff >>> 7;
      if (s8_bad_ff) begin
         s9_in = '0;
      end else begin
         s9_in.pressure_q8    = 32'(p_sh);
         s9_in.temperature_q8 = s8_t_ff;
         s9_in.result_valid   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
      if (en[0]) begin
         s7_bad_ff   <= in_data.bad;
         s7_off_ff   <= in_data.off;
         s7_pp_lo_ff <= s7_pp_lo_in;
         s7_pp_hi_ff <= s7_pp_hi_in;
         s7_tm_ff    <= s7_tm_in;
      end
      if (en[1]) begin
         s8_bad_ff <= s7_bad_ff;
         s8_off_ff <= s7_off_ff;
         s8_q_ff   <= s8_q_in;
         s8_t_ff   <= s8_t_in;
      end
      if (en[2]) begin
         s9_ff <= s9_in;
      end
   end

   assign out_valid = v_ff[2];
   assign out_data  = s9_ff;

endmodule

FILE: rtl/core/barometric_pressure_compensation.sv
// Channel   Ports                            Beat
// -------   ------------------------------   ----------------------------------
// request   req_valid req_ready req_data     raw pressure + raw temperature
// response  rsp_valid rsp_ready rsp_data     pressure_q8, temperature_q8, flag
// csr       csr_valid csr_ready csr_index    one calibration/variant register
//           csr_data
//
// Nine register stages, one beat per cycle sustained while rsp_ready stays high.
// The multiplier stages (dT products, squares, P*SENS split into two
// 24x20 partial products) are each followed by a register.
// Reset (synchronous) clears the valid bits and the calibration registers.
// Each stage holds while the one after it is full and stalled; bubbles are
// squeezed out, so req_ready stays high while rsp_data waits if room remains.
// csr_ready is always high; writes land the next cycle.
`include "barometric_pressure_compensation_defines.svh"

module barometric_pressure_compensation (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bpc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bpc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data
);
   import bpc_pkg::*;

   cfg_type   cfg_ff, cfg_in;

   logic      first_valid, first_ready;
   first_type first_data;
   logic      corr_valid, corr_ready;
   corr_type  corr_data;

   // calibration register file; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_PRESS_SENS: cfg_in.press_sens = csr_data;
            REG_PRESS_OFF:  cfg_in.press_off  = csr_data;
            REG_SENS_TCO:   cfg_in.sens_tco   = csr_data;
            REG_OFF_TCO:    cfg_in.off_tco    = csr_data;
            REG_REF_TEMP:   cfg_in.ref_temp   = csr_data;
            REG_TEMP_SENS:  cfg_in.temp_sens  = csr_data;
            REG_VARIANT:    cfg_in.variant    = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // dT, first-order TEMP/OFF/SENS, T2
   bpc_first u_first (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (first_valid),
      .out_ready (first_ready),
      .out_data  (first_data)
   );

   // low-temperature corrections
   bpc_corr u_corr (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (first_valid),
      .in_ready  (first_ready),
      .in_data   (first_data),
      .out_valid (corr_valid),
      .out_ready (corr_ready),
      .out_data  (corr_data)
   );

   // final P and T, output register
   bpc_final u_final (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (corr_valid),
      .in_ready  (corr_ready),
      .in_data   (corr_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // empty output stage means the whole chain can advance
   `BPC_ASSERT(a_ready_when_drained, clock, reset, !rsp_valid |-> req_ready)
   // a rejected sample carries zero payload
   `BPC_ASSERT(a_zero_on_invalid, clock, reset,
      (rsp_valid && !rsp_data.result_valid) |->
         (rsp_data.pressure_q8 == 0 && rsp_data.temperature_q8 == 0))
   // nothing leaves the cycle after reset
   `BPC_ASSERT_ALWAYS(a_empty_after_reset, clock, $past(reset) |-> !rsp_valid)
   // a stalled result stays up with its payload held
   `BPC_ASSERT(a_stall_holds_rsp, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))

endmodule
